FILE: hdl/cgpm_pkg.sv
// ----------------------------------------------------------------------------
// cgpm_pkg
// Shared constants, codes and helpers of the cyclic GF(2) polynomial multiplier.
// ----------------------------------------------------------------------------
package cgpm_pkg;

  // Polynomial size and storage layout
  localparam int unsigned POLY_BITS     = 67699;
  localparam int unsigned OPERAND_WORDS = 1058;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned PRODUCT_WORDS = 2 * OPERAND_WORDS;

  // Carry-less multiply digit: bits of the second word taken per cycle
  localparam int unsigned DIGIT_BITS = 16;
  localparam int unsigned DIGITS     = WORD_BITS / DIGIT_BITS;
  localparam int unsigned GW         = $clog2(DIGITS);

  // Fold offset: word and bit part of POLY_BITS
  localparam int unsigned WORD_SHIFT = POLY_BITS / WORD_BITS;
  localparam int unsigned BIT_SHIFT  = POLY_BITS % WORD_BITS;

  // Index widths
  localparam int unsigned AW   = $clog2(OPERAND_WORDS);
  localparam int unsigned KW   = $clog2(OPERAND_WORDS + 1);
  localparam int unsigned PAW  = $clog2(PRODUCT_WORDS);
  localparam int unsigned SUMW = $clog2(OPERAND_WORDS + WORD_SHIFT + 2);

  // Valid bits of the word that holds coefficient POLY_BITS-1
  localparam logic [WORD_BITS-1:0] PART_MASK =
    (64'd1 << BIT_SHIFT) - 64'd1;

  typedef enum logic [1:0] {
    CMD_LOAD_A   = 2'd0,
    CMD_LOAD_B   = 2'd1,
    CMD_MULTIPLY = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_FOLD = 3'b100
  } state_e;

  // Mask of the coefficient bits of word idx that lie below POLY_BITS
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [PAW-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    if (w < WORD_SHIFT) begin
      return '1;
    end else if (w == WORD_SHIFT) begin
      return PART_MASK;
    end else begin
      return '0;
    end
  endfunction

endpackage

FILE: hdl/cyclic_gf2_poly_multiply.sv
// ----------------------------------------------------------------------------
// cyclic_gf2_poly_multiply
// Product of two binary polynomials reduced modulo x^POLY_BITS - 1.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid_i / in_stall_o) carries a command, a word
// index and a data word; one output channel (out_valid_o / out_stall_i) carries
// result words. Load commands write one operand word per cycle while the input
// is not stalled into the operand RAMs. A multiply runs the word-serial
// product: for each word of the first operand it streams all words of the
// second operand through one carry-less unit that takes 16 bits of the second
// word per cycle, accumulating into a product RAM, then a fold pass XORs the
// high half back down in place. A multiply holds the input stalled until the
// fold pass has finished. A read command's word passes through the registered
// product RAM read port and then the result register; the input stays stalled
// until that item has left the output register. Reset clears control state
// only; the RAMs hold no defined contents until written. A stalled output
// holds its item.
// ----------------------------------------------------------------------------
module cyclic_gf2_poly_multiply import cgpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [10:0] word_index_i,
  input  logic [63:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_word_o
);

  // Memories
  logic [WORD_BITS-1:0] opa_mem [OPERAND_WORDS];
  logic [WORD_BITS-1:0] opb_mem [OPERAND_WORDS];
  logic [WORD_BITS-1:0] acc_mem [PRODUCT_WORDS];

  // Control state
  state_e          state_q;
  logic [AW-1:0]   i_q;
  logic [KW-1:0]   k_q;
  logic [GW-1:0]   gap_q;
  logic            mul_done_q;
  logic [AW-1:0]   f_q;
  logic            f_run_q, f_prime_q;
  logic            fp_q, fv_q;
  logic            fs_ok_q, fs1_ok_q;
  logic [AW-1:0]   fi_q;
  logic            rd_pend_q, rd_oor_q;
  logic            out_valid_q;
  logic            s1_valid_q;

  // Datapath registers
  logic [WORD_BITS-1:0] opa_rd_q, opb_rd_q, acc_rd_a_q, acc_rd_b_q;
  logic [WORD_BITS-1:0] hold_q, result_q;
  logic                 s1_tail_q, s1_first_q, s1_k0_q;
  logic [PAW-1:0]       s1_addr_q, s2_addr_q;
  logic [AW-1:0]        s1_i_q;
  logic [KW-1:0]        s1_k_q;
  logic                 s2_k0_q;
  logic [WORD_BITS-1:0] s2_acc_q, hi_prev_q;

  // Combinational signals
  cmd_e                 cmd;
  logic                 in_acc, idx_ok;
  logic                 mul_issue, mul_tail;
  logic                 fold_issue;
  logic [SUMW-1:0]      fsum;
  logic                 s_ok, s1_ok, prime_ok;
  logic [PAW-1:0]       acc_ra, acc_rb, acc_wa, mul_addr;
  logic                 acc_we;
  logic [WORD_BITS-1:0] acc_wd, fold_word, fold_sh;
  logic [AW-1:0]        opb_ra;
  logic [WORD_BITS-1:0] cl_a, cl_b, cl_lo, cl_hi, s1_acc;
  logic                 cl_done;

  // Input handshake
  assign cmd        = cmd_e'(command_i);
  assign in_stall_o = (state_q != ST_IDLE) || rd_pend_q || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_ok     = 32'(word_index_i) < OPERAND_WORDS;

  // Multiply sequencing signals: a new word pair issues when the gap counter is zero
  assign mul_issue = (state_q == ST_MUL) && (gap_q == '0) && !mul_done_q;
  assign mul_tail  = (k_q == KW'(OPERAND_WORDS));
  assign mul_addr  = PAW'(i_q) + PAW'(k_q);
  assign opb_ra    = mul_tail ? '0 : k_q[AW-1:0];

  // Fold sequencing signals
  assign fold_issue = (state_q == ST_FOLD) && f_run_q;
  assign fsum       = SUMW'(f_q) + SUMW'(WORD_SHIFT);
  assign s_ok       = 32'(fsum) < PRODUCT_WORDS;
  assign s1_ok      = 32'(fsum) + 32'd1 < PRODUCT_WORDS;
  assign prime_ok   = WORD_SHIFT < PRODUCT_WORDS;

  // Product RAM read addresses
  always_comb begin
    case (state_q)
      ST_MUL:  acc_ra = mul_addr;
      ST_FOLD: acc_ra = PAW'(f_q);
      default: acc_ra = PAW'(word_index_i[AW-1:0]);
    endcase
    if (f_prime_q) begin
      acc_rb = prime_ok ? PAW'(WORD_SHIFT) : '0;
    end else begin
      acc_rb = s1_ok ? PAW'(fsum + SUMW'(1)) : '0;
    end
  end

  // Partial product of the current word pair
  assign cl_a   = opa_rd_q & word_mask(PAW'(s1_i_q));
  assign cl_b   = s1_tail_q ? '0 : (opb_rd_q & word_mask(PAW'(s1_k_q)));
  assign s1_acc = (s1_first_q || s1_tail_q) ? '0 : acc_rd_a_q;

  cgpm_clmul u_clmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s1_valid_q),
    .a_i     (cl_a),
    .b_i     (cl_b),
    .done_o  (cl_done),
    .lo_o    (cl_lo),
    .hi_o    (cl_hi)
  );

  // Fold: low word XOR product shifted down by POLY_BITS, masked
  always_comb begin
    fold_sh = fs_ok_q ? (hold_q >> BIT_SHIFT) : '0;
    if ((BIT_SHIFT != 0) && fs1_ok_q) begin
      fold_sh = fold_sh | (acc_rd_b_q << (WORD_BITS - BIT_SHIFT));
    end
    fold_word = (acc_rd_a_q ^ fold_sh) & word_mask(PAW'(fi_q));
  end

  // Product RAM write port: accumulate, else fold
  always_comb begin
    acc_we = cl_done || fv_q;
    if (cl_done) begin
      acc_wa = s2_addr_q;
      acc_wd = s2_acc_q ^ cl_lo ^ (s2_k0_q ? '0 : hi_prev_q);
    end else begin
      acc_wa = PAW'(fi_q);
      acc_wd = fold_word;
    end
  end

  // Operand RAMs
  always_ff @(posedge clk_i) begin
    if (in_acc && idx_ok && (cmd == CMD_LOAD_A)) begin
      opa_mem[word_index_i[AW-1:0]] <= data_word_i;
    end
    if (in_acc && idx_ok && (cmd == CMD_LOAD_B)) begin
      opb_mem[word_index_i[AW-1:0]] <= data_word_i;
    end
    opa_rd_q <= opa_mem[i_q];
    opb_rd_q <= opb_mem[opb_ra];
  end

  // Product RAM, two registered read ports
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd_a_q <= acc_mem[acc_ra];
    acc_rd_b_q <= acc_mem[acc_rb];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      k_q        <= '0;
      gap_q      <= '0;
      mul_done_q <= 1'b0;
      f_q        <= '0;
      f_run_q    <= 1'b0;
      f_prime_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd == CMD_MULTIPLY)) begin
            state_q    <= ST_MUL;
            i_q        <= '0;
            k_q        <= '0;
            gap_q      <= '0;
            mul_done_q <= 1'b0;
          end
        end
        ST_MUL: begin
          if (mul_issue) begin
            gap_q <= GW'(DIGITS - 1);
            if (mul_tail) begin
              k_q <= '0;
              if (i_q == AW'(OPERAND_WORDS - 1)) begin
                mul_done_q <= 1'b1;
              end else begin
                i_q <= i_q + AW'(1);
              end
            end else begin
              k_q <= k_q + KW'(1);
            end
          end else if (gap_q != '0) begin
            gap_q <= gap_q - GW'(1);
            if ((gap_q == GW'(1)) && mul_done_q) begin
              state_q   <= ST_FOLD;
              f_q       <= '0;
              f_run_q   <= 1'b1;
              f_prime_q <= 1'b1;
            end
          end
        end
        ST_FOLD: begin
          if (f_run_q) begin
            if (f_prime_q) begin
              f_prime_q <= 1'b0;
            end else if (f_q == AW'(OPERAND_WORDS - 1)) begin
              f_run_q <= 1'b0;
            end else begin
              f_q <= f_q + AW'(1);
            end
          end else if (fv_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Pipeline and handshake control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fp_q        <= 1'b0;
      fv_q        <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= mul_issue;
      fp_q       <= fold_issue && f_prime_q;
      fv_q       <= fold_issue && !f_prime_q;
      rd_pend_q  <= in_acc && (cmd == CMD_READ);
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    // issue -> clmul start
    s1_tail_q  <= mul_tail;
    s1_first_q <= (i_q == '0);
    s1_k0_q    <= (k_q == '0);
    s1_addr_q  <= mul_addr;
    s1_i_q     <= i_q;
    s1_k_q     <= k_q;
    // clmul start -> accumulate write, held over the digit cycles
    if (s1_valid_q) begin
      s2_k0_q   <= s1_k0_q;
      s2_addr_q <= s1_addr_q;
      s2_acc_q  <= s1_acc;
    end
    if (cl_done) begin
      hi_prev_q <= cl_hi;
    end
    // fold stage
    fi_q     <= f_q;
    fs_ok_q  <= s_ok;
    fs1_ok_q <= s1_ok;
    if (fp_q) begin
      hold_q <= prime_ok ? acc_rd_b_q : '0;
    end else if (fv_q) begin
      hold_q <= acc_rd_b_q;
    end
    // read path
    rd_oor_q <= !idx_ok;
    if (rd_pend_q) begin
      result_q <= rd_oor_q ? '0 : acc_rd_a_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_word_o = result_q;

  // Checks
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cl_done && fv_q))
    else $error("accumulate and fold write the product RAM together");

  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(rd_pend_q))
    else $error("result item without a read");

  a_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_IDLE) && !out_valid_q)
    else $error("read pending outside idle");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (32'(k_q) <= OPERAND_WORDS))
    else $error("operand word counter out of range");

endmodule

FILE: hdl/cgpm_clmul.sv
// ----------------------------------------------------------------------------
// cgpm_clmul
// Carry-less 64x64 multiply, one 16-bit digit of the second word per cycle.
// ----------------------------------------------------------------------------
module cgpm_clmul import cgpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] lo_o,
  output logic [WORD_BITS-1:0] hi_o
);

  logic                   busy_q, done_q;
  logic [GW-1:0]          cnt_q;
  logic [WORD_BITS-1:0]   a_q, b_q, op_a;
  logic [DIGIT_BITS-1:0]  digit;
  logic [2*WORD_BITS-1:0] pp, prod_q, prod_d;

  // Top digit times the first word, folded into the running product
  always_comb begin
    op_a  = start_i ? a_i : a_q;
    digit = start_i ? b_i[WORD_BITS-1 -: DIGIT_BITS] : b_q[WORD_BITS-1 -: DIGIT_BITS];
    pp    = '0;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      if (digit[j]) begin
        pp = pp ^ ({{WORD_BITS{1'b0}}, op_a} << j);
      end
    end
    prod_d = start_i ? pp : ((prod_q << DIGIT_BITS) ^ pp);
  end

  // Digit sequencing: first digit on start, the rest while busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == GW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= GW'(DIGITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - GW'(1);
        if (cnt_q == GW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand shift register and product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i << DIGIT_BITS;
      prod_q <= prod_d;
    end else if (busy_q) begin
      b_q    <= b_q << DIGIT_BITS;
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign lo_o   = prod_q[WORD_BITS-1:0];
  assign hi_o   = prod_q[2*WORD_BITS-1:WORD_BITS];

endmodule
